>>> sv/fccw_pkg.sv
// Shared types, codes and helper functions for the FAT cluster chain walker.
package fccw_pkg;

    localparam int unsigned TableEntriesDef = 4096;
    localparam int unsigned MaxRunDef       = 64;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_TOTAL_SECTORS   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SECTORS_PER_FAT = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_RESERVED        = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TABLE_COPIES    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ROOT_ENTRIES    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_BYTES_PER_SEC   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_SEC_PER_CLUS    = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_ROOT_CLUSTER    = 3'd7;

    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_WALK  = 1'b1;

    localparam logic [31:0] FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT = 32'd65525;

    typedef logic [31:0] t_word;

    // Cluster validity under the reserved-value rules of FAT12 and FAT32; no FAT16 cluster is valid.
    function automatic logic fn_valid(input t_word c, input logic [1:0] kind,
                                      input t_word root);
        logic in12;
        logic in16;
        logic ok;
        in12 = (c >= 32'h0000_0ff8) && (c <= 32'h0000_0fff);
        in16 = (c >= 32'h0000_fff8) && (c <= 32'h0000_ffff);
        ok   = 1'b0;
        if (kind == KIND_FAT12) begin
            ok = (c >= 32'd2) && !in12;
        end else if (kind == KIND_FAT32) begin
            ok = (c >= root) && !in12 && !in16 && (c != 32'h0fff_ffff);
        end
        return ok;
    endfunction

endpackage

>>> sv/fccw_in_if.sv
// Input channel: table writes and walk requests.
interface fccw_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [11:0] entry_index;
    logic [31:0] entry_value;
    logic [31:0] first_cluster;

    modport source (output valid, func, entry_index, entry_value, first_cluster,
                    input ready);
    modport sink (input valid, func, entry_index, entry_value, first_cluster,
                  output ready);
endinterface

>>> sv/fccw_out_if.sv
// Output channel: one word per cluster of a walked chain, or a single word for an empty one.
interface fccw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] cluster;
    logic [31:0] sector;
    logic [5:0]  position;
    logic [1:0]  fat_type;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, cluster, sector, position, fat_type, status, last,
                    input ready);
    modport sink (input valid, cluster, sector, position, fat_type, status, last,
                  output ready);
endinterface

>>> sv/fccw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fccw_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/fat_cluster_chain_walker.sv
// Top level of the FAT cluster chain walker: sequencer, shared divider, table RAM.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    func, entry_index, entry_value, first_cluster
//  out_ch    out  valid / ready    cluster, sector, position, fat_type, status, last
//  i_cfg_*   in   i_cfg_we only    i_cfg_idx, i_cfg_data
//
// A table write is taken while the sequencer is idle. A walk runs the shared
// restoring divider twice (the root area, then the cluster count), checks the
// first cluster, then passes each chain word through step, table RAM read and
// output hold, the hold lasting for as long as the sink stalls.
// Reset is synchronous, active low; it clears the sequencer and loads the
// register defaults. The table RAM is not cleared. in_ch.ready is high only
// while the sequencer is idle.
module fat_cluster_chain_walker
    import fccw_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
    parameter int unsigned MAX_RUN       = MaxRunDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    fccw_in_if.sink             in_ch,
    fccw_out_if.source          out_ch
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam logic [31:0] TableLim = 32'(TABLE_ENTRIES);
    localparam logic [5:0]  RunLast  = 6'(MAX_RUN - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_CHECK = 6'b000100,
        S_STEP  = 6'b001000,
        S_LOOK  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    // Geometry registers
    t_word       r_total, r_spf, r_root_clus;
    logic [15:0] r_resv, r_root_ent, r_bps;
    logic [7:0]  r_copies, r_spc;

    t_state      r_state, n_state;
    logic        r_phase;
    logic [4:0]  r_dcnt;
    t_word       r_dvd;
    logic [15:0] r_rem, r_dsr;
    t_word       r_tarea, r_root, r_base, r_mulc, r_clus;
    logic [1:0]  r_kind;
    logic [5:0]  r_cnt;

    // Output holding register
    t_word       r_o_clus, r_o_sec;
    logic [5:0]  r_o_pos;
    logic [1:0]  r_o_stat;
    logic        r_o_last;

    // RAM
    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_word       ram_rdata;
    t_word       wr_idx_ext;

    // Divider step
    logic [16:0] div_t;
    logic        div_ge;
    logic [1:0]  kind_calc;
    logic        nx_valid, clus_outside;

    fccw_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(in_ch.entry_value),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign in_ch.ready = (r_state == S_IDLE);
    assign wr_idx_ext  = {20'd0, in_ch.entry_index};
    // Drop writes beyond the table.
    assign ram_we    = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_WRITE)
                       && (wr_idx_ext < TableLim);
    assign ram_waddr = wr_idx_ext[AW-1:0];
    assign ram_raddr = r_clus[AW-1:0];

    assign div_t  = {r_rem, r_dvd[31]};
    assign div_ge = div_t >= {1'b0, r_dsr};

    always_comb begin
        if (r_dvd < FAT12_LIMIT) begin
            kind_calc = KIND_FAT12;
        end else if (r_dvd < FAT16_LIMIT) begin
            kind_calc = KIND_FAT16;
        end else begin
            kind_calc = KIND_FAT32;
        end
    end

    assign clus_outside = r_clus >= TableLim;
    assign nx_valid     = fn_valid(ram_rdata, r_kind, r_root_clus);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_spf       <= '0;
            r_resv      <= '0;
            r_copies    <= 8'd2;
            r_root_ent  <= '0;
            r_bps       <= 16'd512;
            r_spc       <= 8'd1;
            r_root_clus <= 32'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOTAL_SECTORS:   r_total     <= i_cfg_data;
                CFG_SECTORS_PER_FAT: r_spf       <= i_cfg_data;
                CFG_RESERVED:        r_resv      <= i_cfg_data[15:0];
                CFG_TABLE_COPIES:    r_copies    <= i_cfg_data[7:0];
                CFG_ROOT_ENTRIES:    r_root_ent  <= i_cfg_data[15:0];
                CFG_BYTES_PER_SEC:   r_bps       <= i_cfg_data[15:0];
                CFG_SEC_PER_CLUS:    r_spc       <= i_cfg_data[7:0];
                CFG_ROOT_CLUSTER:    r_root_clus <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_ch.valid && in_ch.func == FUNC_WALK) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_dcnt == 5'd31 && r_phase) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // r_kind is only loaded here; check with the fresh type.
                if (fn_valid(r_clus, kind_calc, r_root_clus)) begin
                    n_state = S_STEP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_STEP: n_state = S_LOOK;
            S_LOOK: n_state = S_EMIT;
            S_EMIT: begin
                if (out_ch.ready) begin
                    n_state = r_o_last ? S_IDLE : S_STEP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_dcnt  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_phase <= 1'b0;
                    r_dcnt  <= '0;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_phase <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_ch.ready && !r_o_last) begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath: divider, geometry and chain registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                // Load the root area division: root_entries*32 / bytes_per_sector.
                r_clus  <= in_ch.first_cluster;
                r_tarea <= 32'(r_copies) * r_spf;
                r_dvd   <= {11'd0, r_root_ent, 5'd0};
                r_rem   <= '0;
                r_dsr   <= (r_bps == 16'd0) ? 16'd1 : r_bps;
            end
            S_DIV: begin
                if (r_dcnt == 5'd31 && !r_phase) begin
                    // Root area done; start the cluster count division.
                    r_root <= {r_dvd[30:0], div_ge};
                    r_dvd  <= r_total - 32'(r_resv) - r_tarea - {r_dvd[30:0], div_ge};
                    r_rem  <= '0;
                    r_dsr  <= (r_spc == 8'd0) ? 16'd1 : {8'd0, r_spc};
                end else begin
                    r_rem <= div_ge ? 16'(div_t - {1'b0, r_dsr}) : div_t[15:0];
                    r_dvd <= {r_dvd[30:0], div_ge};
                end
            end
            S_CHECK: begin
                r_kind   <= kind_calc;
                r_base   <= 32'(r_resv) + r_tarea
                            + ((kind_calc == KIND_FAT12) ? r_root : 32'd0);
                r_o_clus <= '0;
                r_o_sec  <= '0;
                r_o_pos  <= '0;
                r_o_stat <= ST_EMPTY;
                r_o_last <= 1'b1;
            end
            S_STEP: begin
                r_mulc <= (r_clus - 32'd2) * 32'(r_spc);
            end
            S_LOOK: begin
                r_o_clus <= r_clus;
                r_o_sec  <= r_base + r_mulc;
                r_o_pos  <= r_cnt;
                if (clus_outside) begin
                    r_o_stat <= ST_OUTSIDE;
                    r_o_last <= 1'b1;
                end else if (!nx_valid) begin
                    r_o_stat <= ST_OK;
                    r_o_last <= 1'b1;
                end else if (r_cnt == RunLast) begin
                    r_o_stat <= ST_TRUNCATED;
                    r_o_last <= 1'b1;
                end else begin
                    r_o_stat <= ST_OK;
                    r_o_last <= 1'b0;
                    r_clus   <= ram_rdata;
                end
            end
            default: ;
        endcase
    end

    // Drive the result channel from the holding register.
    assign out_ch.valid    = (r_state == S_EMIT);
    assign out_ch.cluster  = r_o_clus;
    assign out_ch.sector   = r_o_sec;
    assign out_ch.position = r_o_pos;
    assign out_ch.fat_type = r_kind;
    assign out_ch.status   = r_o_stat;
    assign out_ch.last     = r_o_last;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while a word is pending");
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.status == ST_EMPTY) |->
        (out_ch.last && out_ch.position == 6'd0 && out_ch.cluster == 32'd0))
        else $error("empty chain word malformed");
    a_run_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.position <= RunLast))
        else $error("chain position beyond run limit");
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
        else $error("walker not idle after final word");
`endif
endmodule

>>> dv/testbench.sv
// Testbench for the FAT cluster chain walker: directed and random walks checked word by word.
module testbench;
    import fccw_pkg::*;

    localparam int unsigned TABLE_SIZE = TableEntriesDef;
    localparam int unsigned RUN_LIMIT  = MaxRunDef;

    typedef struct packed {
        logic [31:0] cluster;
        logic [31:0] sector;
        logic [5:0]  position;
        logic [1:0]  fat_type;
        logic [1:0]  status;
        logic        last;
    } chain_word_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    fccw_in_if  in_ch ();
    fccw_out_if out_ch ();

    fat_cluster_chain_walker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // Shadow copy of the volume geometry and of the allocation table.
    logic [31:0] geo_total;
    logic [31:0] geo_spf;
    logic [15:0] geo_reserved;
    logic [7:0]  geo_copies;
    logic [15:0] geo_root_entries;
    logic [15:0] geo_bps;
    logic [7:0]  geo_spc;
    logic [31:0] geo_root_cluster;
    logic [31:0] fat_shadow [TABLE_SIZE];
    bit          fat_written [TABLE_SIZE];

    chain_word_t expected_words[$];
    int          mismatches;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous hard stop; the slowest legal run is far shorter.
    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] root_sectors();
        logic [31:0] div;
        div = (geo_bps == 16'd0) ? 32'd1 : {16'd0, geo_bps};
        return ({16'd0, geo_root_entries} * 32'd32) / div;
    endfunction

    // Classify the volume from the cluster count; all arithmetic wraps at 32 bits.
    function automatic logic [1:0] volume_kind();
        logic [31:0] div;
        logic [31:0] data;
        logic [31:0] count;
        div   = (geo_spc == 8'd0) ? 32'd1 : {24'd0, geo_spc};
        data  = geo_total - {16'd0, geo_reserved} - {24'd0, geo_copies} * geo_spf
                - root_sectors();
        count = data / div;
        if (count < 32'd4085) return KIND_FAT12;
        if (count < 32'd65525) return KIND_FAT16;
        return KIND_FAT32;
    endfunction

    function automatic bit cluster_ok(input logic [31:0] c, input logic [1:0] kind);
        bit low_eoc;
        bit mid_eoc;
        low_eoc = c >= 32'h0000_0ff8 && c <= 32'h0000_0fff;
        mid_eoc = c >= 32'h0000_fff8 && c <= 32'h0000_ffff;
        if (kind == KIND_FAT12) return c >= 32'd2 && !low_eoc;
        if (kind == KIND_FAT32)
            return c >= geo_root_cluster && !low_eoc && !mid_eoc && c != 32'h0fff_ffff;
        return 1'b0;
    endfunction

    function automatic logic [31:0] first_sector(input logic [31:0] c,
                                                 input logic [1:0] kind);
        logic [31:0] base;
        base = {16'd0, geo_reserved} + {24'd0, geo_copies} * geo_spf;
        if (kind == KIND_FAT12) base = base + root_sectors();
        return base + (c - 32'd2) * {24'd0, geo_spc};
    endfunction

    // Follow a chain through the shadow table. With commit set, queue the words
    // it produces; either way return 0 if it would read an entry never written.
    function automatic bit follow_chain(input logic [31:0] first, input bit commit);
        logic [1:0]  kind;
        logic [31:0] c;
        logic [31:0] nx;
        chain_word_t w;
        int          count;
        bit          fin;
        kind  = volume_kind();
        c     = first;
        count = 0;
        fin   = 1'b0;
        if (!cluster_ok(c, kind)) begin
            if (commit) expected_words.push_back({32'd0, 32'd0, 6'd0, kind, ST_EMPTY, 1'b1});
            return 1'b1;
        end
        while (!fin) begin
            count++;
            w.status = ST_OK;
            nx       = c;
            if (c >= TABLE_SIZE) begin
                w.status = ST_OUTSIDE;
                fin      = 1'b1;
            end else begin
                if (!fat_written[c]) return 1'b0;
                nx = fat_shadow[c];
                if (!cluster_ok(nx, kind)) begin
                    fin = 1'b1;
                end else if (count >= RUN_LIMIT) begin
                    w.status = ST_TRUNCATED;
                    fin      = 1'b1;
                end
            end
            w.cluster  = c;
            w.sector   = first_sector(c, kind);
            w.position = 6'(count - 1);
            w.fat_type = kind;
            w.last     = fin;
            if (commit) expected_words.push_back(w);
            c = nx;
        end
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        chain_word_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                report("unexpected word, cluster", out_ch.cluster, 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (out_ch.cluster !== want.cluster)
                    report("cluster", out_ch.cluster, want.cluster);
                if (out_ch.sector !== want.sector)
                    report("sector", out_ch.sector, want.sector);
                if (out_ch.position !== want.position)
                    report("position", 32'(out_ch.position), 32'(want.position));
                if (out_ch.fat_type !== want.fat_type)
                    report("fat_type", 32'(out_ch.fat_type), 32'(want.fat_type));
                if (out_ch.status !== want.status)
                    report("status", 32'(out_ch.status), 32'(want.status));
                if (out_ch.last !== want.last)
                    report("last", 32'(out_ch.last), 32'(want.last));
            end
        end
    end

    // Stall the result side in random bursts, never while quiet.
    initial begin
        int gap;
        gap = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet || gap == 0) begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
            end else begin
                out_ch.ready <= 1'b0;
                gap--;
            end
        end
    end

    // Send one word, hold it until accepted, then update the shadow state.
    task automatic send_word(input logic func, input logic [11:0] idx,
                             input logic [31:0] value, input logic [31:0] first);
        bit ok;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= func;
        in_ch.entry_index   <= idx;
        in_ch.entry_value   <= value;
        in_ch.first_cluster <= first;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (func == FUNC_WRITE) begin
            if (idx < TABLE_SIZE) begin
                fat_shadow[idx]  = value;
                fat_written[idx] = 1'b1;
            end
        end else begin
            ok = follow_chain(first, 1'b1);
        end
    endtask

    task automatic write_entry(input logic [11:0] idx, input logic [31:0] value);
        send_word(FUNC_WRITE, idx, value, $urandom);
    endtask

    task automatic walk(input logic [31:0] first);
        send_word(FUNC_WALK, 12'($urandom), $urandom, first);
    endtask

    // Walk a random cluster, falling back to cluster 0 if that would touch
    // an entry that was never written.
    task automatic walk_random();
        logic [31:0] first;
        first = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 4200));
        if (!follow_chain(first, 1'b0)) first = 32'd0;
        walk(first);
    endtask

    // Pause the sender until every expected word has come, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_TOTAL_SECTORS:   geo_total        = value;
            CFG_SECTORS_PER_FAT: geo_spf          = value;
            CFG_RESERVED:        geo_reserved     = value[15:0];
            CFG_TABLE_COPIES:    geo_copies       = value[7:0];
            CFG_ROOT_ENTRIES:    geo_root_entries = value[15:0];
            CFG_BYTES_PER_SEC:   geo_bps          = value[15:0];
            CFG_SEC_PER_CLUS:    geo_spc          = value[7:0];
            default:             geo_root_cluster = value;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Build a chain of valid in-table clusters, end it, and walk it from the head.
    task automatic build_and_walk(input int len);
        logic [1:0]  kind;
        logic [31:0] head;
        logic [31:0] cur;
        logic [31:0] nx;
        logic [31:0] tail;
        int          tries;
        kind = volume_kind();
        if (kind == KIND_FAT16 || geo_root_cluster > 32'd4000) begin
            walk_random();
            return;
        end
        tries = 0;
        head  = 32'($urandom_range(2, 4095));
        while (!cluster_ok(head, kind) && tries < 100) begin
            head = 32'($urandom_range(2, 4095));
            tries++;
        end
        cur = head;
        for (int k = 1; k < len; k++) begin
            nx = 32'($urandom_range(2, 4095));
            while (!cluster_ok(nx, kind)) nx = 32'($urandom_range(2, 4095));
            write_entry(cur[11:0], nx);
            cur = nx;
        end
        case ($urandom_range(0, 3))
            0:       tail = 32'h0fff_ffff;
            1:       tail = 32'h0000_0fff;
            2:       tail = 32'd0;
            default: tail = $urandom | 32'h0000_1000;
        endcase
        write_entry(cur[11:0], tail);
        if (!follow_chain(head, 1'b0)) head = 32'd0;
        walk(head);
    endtask

    // Reset geometry is FAT12 with no root area: hit the reserved values, the
    // table edges, a walk leaving the table and a self-loop that truncates.
    task automatic test_fat12_defaults();
        write_entry(12'd0, 32'd0);
        write_entry(12'd4095, 32'hffff_ffff);
        walk(32'd0);
        walk(32'd1);
        walk(32'h0000_0ff8);
        walk(32'h0000_0fff);
        walk(32'hffff_ffff);
        walk(32'd4095);
        write_entry(12'd5, 32'd5);
        walk(32'd5);
        build_and_walk(3);
        drain();
    endtask

    // A mid-size volume is FAT16: every walk comes back empty.
    task automatic test_fat16();
        write_reg(CFG_TOTAL_SECTORS, 32'd40000);
        walk(32'd2);
        walk(32'd4095);
        walk(32'hffff_ffff);
        drain();
    endtask

    // A large volume is FAT32 with a raised root cluster.
    task automatic test_fat32();
        write_reg(CFG_TOTAL_SECTORS, 32'h0100_0000);
        write_reg(CFG_SECTORS_PER_FAT, 32'h0000_0200);
        write_reg(CFG_RESERVED, 32'd32);
        write_reg(CFG_ROOT_CLUSTER, 32'd10);
        walk(32'd9);
        walk(32'h0000_fff8);
        walk(32'h0000_ffff);
        walk(32'h0fff_ffff);
        walk(32'h0000_0ffa);
        walk(32'h0001_0000);
        build_and_walk(4);
        drain();
    endtask

    // Register extremes, including zero divisors and the top root cluster.
    task automatic test_extremes();
        write_reg(CFG_TOTAL_SECTORS, 32'hffff_ffff);
        write_reg(CFG_SECTORS_PER_FAT, 32'hffff_ffff);
        write_reg(CFG_RESERVED, 32'h0000_ffff);
        write_reg(CFG_TABLE_COPIES, 32'h0000_00ff);
        write_reg(CFG_ROOT_ENTRIES, 32'h0000_ffff);
        write_reg(CFG_BYTES_PER_SEC, 32'd1);
        write_reg(CFG_SEC_PER_CLUS, 32'h0000_00ff);
        write_reg(CFG_ROOT_CLUSTER, 32'hffff_ffff);
        repeat (4) walk_random();
        drain();
        write_reg(CFG_BYTES_PER_SEC, 32'd0);
        write_reg(CFG_SEC_PER_CLUS, 32'd0);
        write_reg(CFG_ROOT_CLUSTER, 32'd0);
        write_reg(CFG_TOTAL_SECTORS, 32'd0);
        repeat (4) walk_random();
        drain();
    endtask

    // Random geometry per phase; mostly built chains, some noise writes and walks.
    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(CFG_TOTAL_SECTORS, (phase % 3 == 0) ? 32'($urandom_range(0, 9000))
                      : (phase % 3 == 1) ? 32'($urandom_range(9000, 60000)) : $urandom);
            write_reg(CFG_SECTORS_PER_FAT, 32'($urandom_range(0, 64)));
            write_reg(CFG_RESERVED, 32'($urandom_range(0, 64)));
            write_reg(CFG_TABLE_COPIES, 32'($urandom_range(1, 2)));
            write_reg(CFG_ROOT_ENTRIES, 32'($urandom_range(0, 512)));
            write_reg(CFG_BYTES_PER_SEC, 32'($urandom_range(1, 4096)));
            write_reg(CFG_SEC_PER_CLUS, 32'($urandom_range(1, 255)));
            write_reg(CFG_ROOT_CLUSTER, 32'($urandom_range(2, 200)));
            quiet = (phase == 7);
            for (int n = 0; n < 9; n++) begin
                case ($urandom_range(0, 5))
                    0:       write_entry(12'($urandom), $urandom);
                    1:       walk_random();
                    default: build_and_walk($urandom_range(1, 8));
                endcase
            end
            drain();
        end
    endtask

    initial begin
        mismatches       = 0;
        quiet            = 1'b0;
        geo_total        = 32'd0;
        geo_spf          = 32'd0;
        geo_reserved     = 16'd0;
        geo_copies       = 8'd2;
        geo_root_entries = 16'd0;
        geo_bps          = 16'd512;
        geo_spc          = 8'd1;
        geo_root_cluster = 32'd2;
        foreach (fat_written[k]) fat_written[k] = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.func          = FUNC_WRITE;
        in_ch.entry_index   = '0;
        in_ch.entry_value   = '0;
        in_ch.first_cluster = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fat12_defaults();
        test_fat16();
        test_fat32();
        test_extremes();
        test_random();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
